@@ hw/rtl/kdhd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdhd_pkg
// Shared widths, reset values, register indexes and event codes for the
// keypad debounce / hold detector.
// ----------------------------------------------------------------------------
package kdhd_pkg;

    // Field widths
    localparam int RAW_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int KIND_W    = 2;
    localparam int KEY_IDX_W = 4;
    localparam int CFG_IDX_W = 1;

    // Default key count
    localparam int KEY_COUNT_DEF = 16;

    // Register reset values
    localparam logic [CFG_W-1:0] HOLD_RESET = 16'd500;
    localparam logic [CFG_W-1:0] REL_RESET  = 16'd48;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL  = 1'b1;

    // Event codes
    localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] EV_UP   = 2'd1;
    localparam logic [KIND_W-1:0] EV_HOLD = 2'd2;
    localparam logic [KIND_W-1:0] EV_BAD  = 2'd3;

    // Per-key event found by one lane
    typedef struct packed {
        logic              fire;
        logic [KIND_W-1:0] kind;
    } t_lane_evt;

endpackage

@@ hw/rtl/kdhd_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdhd_lane
// Debounce and hold tracking for a single key. Finds the event caused by
// the current scan and updates the key state when the scan is taken.
// ----------------------------------------------------------------------------
module kdhd_lane
    import kdhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_raw_bit,
    input  logic [TIME_W-1:0] i_now,
    input  logic [CFG_W-1:0]  i_hold_time,
    input  logic [CFG_W-1:0]  i_rel_time,
    output t_lane_evt         o_evt
);

    logic              r_stable, n_stable;
    logic              r_wait,   n_wait;
    logic              r_rep,    n_rep;
    logic [TIME_W-1:0] r_press,  n_press;
    logic [TIME_W-1:0] r_rel,    n_rel;

    logic [TIME_W-1:0] d_hold;
    logic [TIME_W-1:0] d_rel;
    logic              hold_ok;
    logic              rel_ok;

    // Wrap-around elapsed times; negative never reaches a threshold
    assign d_hold  = i_now - r_press;
    assign d_rel   = i_now - r_rel;
    assign hold_ok = !d_hold[TIME_W-1] && (d_hold >= TIME_W'(i_hold_time));
    assign rel_ok  = !d_rel[TIME_W-1]  && (d_rel  >= TIME_W'(i_rel_time));

    // Next key state and event
    always_comb begin
        n_stable   = r_stable;
        n_wait     = r_wait;
        n_rep      = r_rep;
        n_press    = r_press;
        n_rel      = r_rel;
        o_evt.fire = 1'b0;
        o_evt.kind = EV_DOWN;
        if (r_stable) begin
            if (i_raw_bit) begin
                n_wait = 1'b0;
                if (!r_rep && hold_ok) begin
                    n_rep      = 1'b1;
                    o_evt.fire = 1'b1;
                    o_evt.kind = EV_HOLD;
                end
            end else if (!r_wait) begin
                // first released scan only opens the window
                n_wait = 1'b1;
                n_rel  = i_now;
            end else if (rel_ok) begin
                n_stable   = 1'b0;
                n_wait     = 1'b0;
                n_rep      = 1'b0;
                n_press    = '0;
                o_evt.fire = 1'b1;
                o_evt.kind = EV_UP;
            end
        end else if (i_raw_bit) begin
            n_stable   = 1'b1;
            n_press    = i_now;
            n_wait     = 1'b0;
            n_rep      = 1'b0;
            o_evt.fire = 1'b1;
            o_evt.kind = EV_DOWN;
        end
    end

    // State registers, updated on each taken scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_wait   <= 1'b0;
            r_rep    <= 1'b0;
            r_press  <= '0;
            r_rel    <= '0;
        end else if (i_en) begin
            r_stable <= n_stable;
            r_wait   <= n_wait;
            r_rep    <= n_rep;
            r_press  <= n_press;
            r_rel    <= n_rel;
        end
    end

endmodule

@@ hw/rtl/kdhd_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdhd_merge
// Collects the lane events of one scan and sends them out one item per
// cycle unless stalled, in ascending key order, marking the last one.
// ----------------------------------------------------------------------------
module kdhd_merge
    import kdhd_pkg::*;
#(
    parameter int LANES = KEY_COUNT_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_lane_evt            i_evt [LANES],
    input  logic [TIME_W-1:0]    i_now,
    output logic                 o_in_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [KIND_W-1:0]    o_event_kind,
    output logic [KEY_IDX_W-1:0] o_key_index,
    output logic [TIME_W-1:0]    o_event_time,
    output logic                 o_last_event
);

    logic [LANES-1:0]  r_mask, n_mask;
    logic [KIND_W-1:0] r_kind [LANES];
    logic [TIME_W-1:0] r_time;

    logic [LANES-1:0]     first;
    logic [KEY_IDX_W-1:0] idx;
    logic [KIND_W-1:0]    kind_sel;
    logic                 busy;
    logic                 last;
    logic                 pop;

    // Lowest pending key
    assign first = r_mask & (~r_mask + LANES'(1));
    assign busy  = |r_mask;
    assign last  = ~|(r_mask & ~first);
    assign pop   = busy && !i_stall;

    always_comb begin
        idx      = '0;
        kind_sel = '0;
        for (int k = 0; k < LANES; k++) begin
            if (first[k]) begin
                idx      = idx | KEY_IDX_W'(k);
                kind_sel = kind_sel | r_kind[k];
            end
        end
    end

    // Take a new scan once the current one is leaving on its last item
    assign o_in_stall   = busy && !(pop && last);
    assign o_valid      = busy;
    assign o_event_kind = kind_sel;
    assign o_key_index  = idx;
    assign o_event_time = r_time;
    assign o_last_event = last;

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            for (int k = 0; k < LANES; k++) begin
                n_mask[k] = i_evt[k].fire;
            end
        end else if (pop) begin
            n_mask = r_mask & ~first;
        end
    end

    // Pending mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    // Event payload of the held scan
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_time <= i_now;
            for (int k = 0; k < LANES; k++) begin
                r_kind[k] <= i_evt[k].kind;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A scan is never loaded over items still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !(pop && last)) |-> !i_load)
        else $error("scan loaded while events pending");

    // Draining the last item without a new scan leaves the unit empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && last && !i_load) |=> !busy)
        else $error("pending mask not empty after last item");

    // Last flag matches a single pending key
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (last == $onehot(r_mask)))
        else $error("last flag does not match pending mask");

    // A shown event carries a defined code
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (kind_sel != EV_BAD))
        else $error("undefined event kind");
`endif

endmodule

@@ hw/rtl/keypad_debounce_hold_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_debounce_hold_detector_unit
// Per-key press / hold / debounced release detection on raw keypad scans,
// one lane per key, with events serialized in ascending key order.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// scan     in         i_valid / o_stall   i_raw_keys, i_now_time
// event    out        o_valid / i_stall   o_event_kind, o_key_index,
//                                         o_event_time, o_last_event
// config   in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A scan is evaluated by all lanes in the cycle it is taken; key state
// updates at that edge. Its events then leave one per cycle while the
// output is not stalled, up to 16 per scan; a scan with no events does
// not occupy the output. The serializer is the limiting unit.
// A new scan is taken in the cycle the previous scan's last item leaves.
// Synchronous active-low reset clears all key state and restores the
// register defaults. Output stalls back up into the scan channel.
// ----------------------------------------------------------------------------
module keypad_debounce_hold_detector_unit
    import kdhd_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // scan channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [RAW_W-1:0]     i_raw_keys,
    input  logic [TIME_W-1:0]    i_now_time,
    // event channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [KIND_W-1:0]    o_event_kind,
    output logic [KEY_IDX_W-1:0] o_key_index,
    output logic [TIME_W-1:0]    o_event_time,
    output logic                 o_last_event,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Keys past the raw scan width never press, so they get no lane
    localparam int LANES = (KEY_COUNT < RAW_W) ? KEY_COUNT : RAW_W;

    logic [CFG_W-1:0] r_hold_time;
    logic [CFG_W-1:0] r_rel_time;
    logic             accept;
    t_lane_evt        evt [LANES];

    assign accept = i_valid && !o_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time <= HOLD_RESET;
            r_rel_time  <= REL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD: r_hold_time <= i_cfg_data;
                CFG_REL:  r_rel_time  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // One lane per key
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        kdhd_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (accept),
            .i_raw_bit   (i_raw_keys[g]),
            .i_now       (i_now_time),
            .i_hold_time (r_hold_time),
            .i_rel_time  (r_rel_time),
            .o_evt       (evt[g])
        );
    end

    // Event serializer
    kdhd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_evt        (evt),
        .i_now        (i_now_time),
        .o_in_stall   (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_key_index  (o_key_index),
        .o_event_time (o_event_time),
        .o_last_event (o_last_event)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keypad_debounce_hold_detector_unit. A directed
// table covers press, hold, release debounce, re-press cancel, time wrap,
// negative elapsed time and the register extremes. Random phases follow,
// each with its own register setting and one of four idle patterns. Events
// are checked field by field against spelled-out rows or a per-key predictor.
// ----------------------------------------------------------------------------
module testbench;
    import kdhd_pkg::*;

    localparam int KEYS            = 16;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int ROWS            = 31;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [KEY_IDX_W-1:0] key;
        logic [TIME_W-1:0]    stamp;
        logic                 last;
    } t_key_event;

    // One directed row: either a register write or a scan. A scan with
    // spelled_out set carries its events as one kind over a key mask.
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [RAW_W-1:0]     raw;
        logic [TIME_W-1:0]    now;
        logic                 spelled_out;
        logic [KIND_W-1:0]    kind;
        logic [RAW_W-1:0]     keys;
    } t_scan_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [RAW_W-1:0]     i_raw_keys;
    logic [TIME_W-1:0]    i_now_time;
    logic                 o_valid;
    logic                 i_stall;
    logic [KIND_W-1:0]    o_event_kind;
    logic [KEY_IDX_W-1:0] o_key_index;
    logic [TIME_W-1:0]    o_event_time;
    logic                 o_last_event;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    keypad_debounce_hold_detector_unit dut (.*);

    // Predictor state
    logic [CFG_W-1:0]  hold_ms;
    logic [CFG_W-1:0]  release_ms;
    logic [KEYS-1:0]   key_down;
    logic [KEYS-1:0]   release_armed;
    logic [KEYS-1:0]   hold_flagged;
    logic [TIME_W-1:0] press_t   [KEYS];
    logic [TIME_W-1:0] release_t [KEYS];

    t_key_event scan_events[$];
    t_key_event pending_events[$];
    bit         failed;
    int         phase_num;
    int         send_gap_pct;
    int         stall_pct;

    t_scan_row directed_rows [ROWS] = '{
        // reset settings: hold 500, release 48
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'd0,    1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'hFFFF, 32'd10,   1'b1, EV_DOWN, 16'hFFFF},
        '{1'b0, CFG_HOLD, 16'd0, 16'hFFFF, 32'd100,  1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'hFFFF, 32'd510,  1'b1, EV_HOLD, 16'hFFFF},
        '{1'b0, CFG_HOLD, 16'd0, 16'hFFFF, 32'd2000, 1'b1, EV_DOWN, 16'h0000},
        // release window opens, key 0 re-pressed inside it
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'd2001, 1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0001, 32'd2010, 1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'd2049, 1'b1, EV_UP,   16'hFFFE},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'd2097, 1'b1, EV_UP,   16'h0001},
        // mixed patterns
        '{1'b0, CFG_HOLD, 16'd0, 16'hA5C3, 32'd3000, 1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h5A3C, 32'd3001, 1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'd3100, 1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'd3200, 1'b0, EV_DOWN, 16'h0000},
        // zero thresholds; time wraps between press and release
        '{1'b1, CFG_HOLD, 16'd0, 16'h0000, 32'd0,    1'b0, EV_DOWN, 16'h0000},
        '{1'b1, CFG_REL,  16'd0, 16'h0000, 32'd0,    1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h8000, 32'hFFFF_FFF0, 1'b1, EV_DOWN, 16'h8000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h8000, 32'hFFFF_FFF0, 1'b1, EV_HOLD, 16'h8000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'h0000_0005, 1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'h0000_0005, 1'b1, EV_UP,   16'h8000},
        // negative elapsed time never reaches a threshold
        '{1'b0, CFG_HOLD, 16'd0, 16'h0008, 32'h1000_0000, 1'b1, EV_DOWN, 16'h0008},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0008, 32'h0FFF_FFFF, 1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0008, 32'h9000_0000, 1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0008, 32'h8FFF_FFFF, 1'b1, EV_HOLD, 16'h0008},
        // maximum thresholds
        '{1'b1, CFG_HOLD, 16'hFFFF, 16'h0000, 32'd0, 1'b0, EV_DOWN, 16'h0000},
        '{1'b1, CFG_REL,  16'hFFFF, 16'h0000, 32'd0, 1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'h0000_0000, 1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'h0000_FFFE, 1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'h0000, 32'h0000_FFFF, 1'b1, EV_UP,   16'h0008},
        '{1'b0, CFG_HOLD, 16'd0, 16'hFFFF, 32'h0001_0000, 1'b0, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'hFFFF, 32'h0001_FFFE, 1'b1, EV_DOWN, 16'h0000},
        '{1'b0, CFG_HOLD, 16'd0, 16'hFFFF, 32'h0001_FFFF, 1'b1, EV_HOLD, 16'hFFFF}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Signed wrap-around elapsed time test
    function automatic bit reached(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] since,
                                   input logic [CFG_W-1:0]  limit);
        logic [TIME_W-1:0] diff;
        diff = now - since;
        return !diff[TIME_W-1] && (diff >= {16'd0, limit});
    endfunction

    // Per-key debounce / hold prediction for one scan; fills scan_events
    function automatic void predict_scan(input logic [RAW_W-1:0]  raw,
                                         input logic [TIME_W-1:0] now);
        t_key_event ev;
        scan_events.delete();
        for (int k = 0; k < KEYS; k++) begin
            ev = '{EV_DOWN, k[KEY_IDX_W-1:0], now, 1'b0};
            if (key_down[k]) begin
                if (raw[k]) begin
                    release_armed[k] = 1'b0;
                    if (!hold_flagged[k] && reached(now, press_t[k], hold_ms)) begin
                        hold_flagged[k] = 1'b1;
                        ev.kind = EV_HOLD;
                        scan_events.push_back(ev);
                    end
                end else if (!release_armed[k]) begin
                    release_armed[k] = 1'b1;
                    release_t[k]     = now;
                end else if (reached(now, release_t[k], release_ms)) begin
                    key_down[k]      = 1'b0;
                    release_armed[k] = 1'b0;
                    hold_flagged[k]  = 1'b0;
                    press_t[k]       = '0;
                    ev.kind = EV_UP;
                    scan_events.push_back(ev);
                end
            end else if (raw[k]) begin
                key_down[k]      = 1'b1;
                press_t[k]       = now;
                release_armed[k] = 1'b0;
                hold_flagged[k]  = 1'b0;
                scan_events.push_back(ev);
            end
        end
        if (scan_events.size() > 0)
            scan_events[scan_events.size()-1].last = 1'b1;
    endfunction

    // Register write; the task waits with write-enable low before returning, which keeps write-enable pulses apart
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_HOLD)
            hold_ms = val;
        else
            release_ms = val;
        @(posedge i_clk);
    endtask

    // Offer one scan after an optional gap; predict once it is taken
    task automatic drive_scan(input logic [RAW_W-1:0]  raw,
                              input logic [TIME_W-1:0] now,
                              input int                gap,
                              input bit                spelled_out,
                              input logic [KIND_W-1:0] kind,
                              input logic [RAW_W-1:0]  keys);
        t_key_event ev;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_raw_keys <= raw;
        i_now_time <= now;
        do @(posedge i_clk); while (o_stall);
        predict_scan(raw, now);
        if (spelled_out) begin
            scan_events.delete();
            for (int k = 0; k < KEYS; k++) begin
                if (keys[k]) begin
                    ev = '{kind, k[KEY_IDX_W-1:0], now, 1'b0};
                    scan_events.push_back(ev);
                end
            end
            if (scan_events.size() > 0)
                scan_events[scan_events.size()-1].last = 1'b1;
        end
        foreach (scan_events[i])
            pending_events.push_back(scan_events[i]);
    endtask

    // Wait until every expected event is out and the block has gone quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Event sink: random stall, plus one long hold-off in the pressure phase
    initial begin : event_sink
        int  holdoff;
        bit  pressure_done;
        holdoff       = 0;
        pressure_done = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!pressure_done && phase_num == PRESSURE_PHASE) begin
                holdoff       = HOLDOFF_CYCLES;
                pressure_done = 1'b1;
            end
            if (holdoff > 0) begin
                holdoff--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Event checker
    always @(posedge i_clk) begin : event_check
        t_key_event want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d key %0d time %h",
                       o_event_kind, o_key_index, o_event_time);
                failed = 1'b1;
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, o_event_kind);
                    failed = 1'b1;
                end
                if (o_key_index !== want.key) begin
                    $error("key_index: expected %0d, got %0d", want.key, o_key_index);
                    failed = 1'b1;
                end
                if (o_event_time !== want.stamp) begin
                    $error("event_time: expected %h, got %h", want.stamp, o_event_time);
                    failed = 1'b1;
                end
                if (o_last_event !== want.last) begin
                    $error("last_event: expected %0d, got %0d", want.last, o_last_event);
                    failed = 1'b1;
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [RAW_W-1:0]  raw;
        logic [TIME_W-1:0] now;
        logic [CFG_W-1:0]  hold_val;
        logic [CFG_W-1:0]  rel_val;
        int                gap;
        int                pick;

        failed       = 1'b0;
        phase_num    = -1;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_ms      = HOLD_RESET;
        release_ms   = REL_RESET;
        key_down      = '0;
        release_armed = '0;
        hold_flagged  = '0;
        for (int k = 0; k < KEYS; k++) begin
            press_t[k]   = '0;
            release_t[k] = '0;
        end
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_raw_keys <= '0;
        i_now_time <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_HOLD;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, back to back
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                settle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                drive_scan(directed_rows[r].raw, directed_rows[r].now, 0,
                           directed_rows[r].spelled_out, directed_rows[r].kind,
                           directed_rows[r].keys);
            end
        end

        // Random phases
        raw = 16'hFFFF;
        now = 32'h0002_0000;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin hold_val = HOLD_RESET; rel_val = REL_RESET; end
                1: begin hold_val = '0; rel_val = '0; end
                2: begin hold_val = '1; rel_val = '1; end
                3: begin
                    hold_val = CFG_W'($urandom_range(0, 200));
                    rel_val  = CFG_W'($urandom_range(0, 60));
                end
                4: begin
                    hold_val = CFG_W'($urandom_range(0, 65535));
                    rel_val  = CFG_W'($urandom_range(0, 65535));
                end
                default: begin
                    hold_val = CFG_W'($urandom_range(1, 40));
                    rel_val  = CFG_W'($urandom_range(0, 10));
                end
            endcase
            write_reg(CFG_HOLD, hold_val);
            write_reg(CFG_REL, rel_val);
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 50; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 50; end
                default: begin send_gap_pct = 38; stall_pct = 38; end
            endcase
            phase_num = p;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Mostly slow key changes; some noise and all-on / all-off scans
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    raw = RAW_W'($urandom_range(0, 65535));
                else if (pick < 13)
                    raw = '0;
                else if (pick < 15)
                    raw = '1;
                else
                    raw = raw ^ RAW_W'($urandom & $urandom & $urandom);

                // Time mostly moves forward in small steps
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    now = now + $urandom_range(0, 30);
                else if (pick < 90)
                    now = now + $urandom_range(100, 1000);
                else if (pick < 95)
                    now = now + $urandom_range(60000, 140000);
                else if (pick < 97)
                    now = now - $urandom_range(1, 100);
                else
                    now = $urandom;

                gap = 0;
                while ($urandom_range(0, 99) < send_gap_pct)
                    gap++;
                drive_scan(raw, now, gap, 1'b0, EV_DOWN, '0);
            end
        end

        settle();
        if (!failed && pending_events.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/kdhd_pkg.sv
hw/rtl/kdhd_lane.sv
hw/rtl/kdhd_merge.sv
hw/rtl/keypad_debounce_hold_detector_unit.sv
dv/testbench.sv
